[rtl/hqs_pkg.sv]
// ----------------------------------------------------------------------------
// hqs_pkg
// Shared widths, datapath commands, status and controller states of the
// block sorter.
// ----------------------------------------------------------------------------
package hqs_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // datapath operation for the current cycle
    typedef enum logic [3:0] {
        DP_LOAD,
        DP_INIT,
        DP_RD_KEY,
        DP_KEY_CAP,
        DP_RD_PREV,
        DP_CMP,
        DP_PUT_KEY,
        DP_EMIT_RD,
        DP_EMIT_CAP,
        DP_EMIT_HOLD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_last;    // last item of the block accepted this cycle
        logic cnt_le1;    // block holds at most one element
        logic greater;    // element read is greater than the key
        logic j_one;      // insertion point index is one
        logic i_last;     // key index is the last element of the block
        logic k_last;     // emit index is the last element of the block
        logic out_taken;  // result item accepted this cycle
    } t_dp_stat;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_RD_KEY,
        ST_KEY_CAP,
        ST_RD_PREV,
        ST_CMP,
        ST_PUT_KEY,
        ST_EMIT_RD,
        ST_EMIT_CAP,
        ST_EMIT_HOLD
    } t_state;

endpackage

[rtl/hqs_if.sv]
// ----------------------------------------------------------------------------
// hqs_if
// Valid/ready channels of the block sorter: element input and sorted output.
// ----------------------------------------------------------------------------
interface hqs_in_if;
    import hqs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface hqs_out_if;
    import hqs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      final_res;
    logic                      overflowed;

    modport source (output valid, output sorted_value, output final_res,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input overflowed, output ready);
endinterface

[rtl/hqs_datapath.sv]
// ----------------------------------------------------------------------------
// hqs_datapath
// Element memory, block count, insertion sort indexes and key, and the
// output register; each cycle does what the controller's command asks.
// ----------------------------------------------------------------------------
module hqs_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hqs_pkg::t_dp_cmd i_cmd,
    output hqs_pkg::t_dp_stat o_stat,
    hqs_in_if.sink           i_in,
    hqs_out_if.source        o_out
);
    import hqs_pkg::*;

    logic [VALUE_W-1:0] r_mem [MAX_ITEMS];
    logic [VALUE_W-1:0] r_rdata;
    logic [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]   r_count;
    logic               r_dropped;
    logic [ADDR_W-1:0]  r_i;
    logic [ADDR_W-1:0]  r_j;
    logic [ADDR_W-1:0]  r_k;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_final;
    logic               r_out_ovf;

    logic               in_fire;
    logic               out_fire;
    logic               has_room;
    logic               greater;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [ADDR_W-1:0]  rd_addr;

    assign i_in.ready = (i_cmd.op == DP_LOAD);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_out_valid && o_out.ready;
    assign has_room   = (r_count < CNT_W'(MAX_ITEMS));
    assign greater    = ($signed(r_rdata) > $signed(r_key));

    // status back to the controller
    assign o_stat.in_last   = in_fire && i_in.last;
    assign o_stat.cnt_le1   = (r_count <= CNT_W'(1));
    assign o_stat.greater   = greater;
    assign o_stat.j_one     = (r_j == ADDR_W'(1));
    assign o_stat.i_last    = ((CNT_W'(r_i) + CNT_W'(1)) == r_count);
    assign o_stat.k_last    = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign o_stat.out_taken = out_fire;

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_j;
        wr_data = r_key;
        rd_addr = r_i;
        case (i_cmd.op)
            DP_LOAD: begin
                wr_en   = in_fire && has_room;
                wr_addr = r_count[ADDR_W-1:0];
                wr_data = i_in.value;
            end
            DP_RD_KEY:  rd_addr = r_i;
            DP_RD_PREV: rd_addr = r_j - ADDR_W'(1);
            DP_CMP: begin
                wr_en   = greater;
                wr_data = r_rdata;
            end
            DP_PUT_KEY: wr_en = 1'b1;
            DP_EMIT_RD: rd_addr = r_k;
            default: ;
        endcase
    end

    // element memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                DP_LOAD: begin
                    if (in_fire && has_room) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (in_fire) begin
                        r_dropped <= 1'b1;
                    end
                end
                DP_EMIT_CAP: r_out_valid <= 1'b1;
                DP_EMIT_HOLD: begin
                    if (out_fire) begin
                        r_out_valid <= 1'b0;
                        if (o_stat.k_last) begin
                            r_count   <= '0;
                            r_dropped <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // sort indexes, key and output payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_INIT: begin
                r_i <= ADDR_W'(1);
                r_k <= '0;
            end
            DP_KEY_CAP: begin
                r_key <= r_rdata;
                r_j   <= r_i;
            end
            DP_CMP: begin
                if (greater) begin
                    r_j <= r_j - ADDR_W'(1);
                end
            end
            DP_PUT_KEY: r_i <= r_i + ADDR_W'(1);
            DP_EMIT_CAP: begin
                r_out_value <= r_rdata;
                r_out_final <= o_stat.k_last;
                r_out_ovf   <= r_dropped;
            end
            DP_EMIT_HOLD: begin
                if (out_fire) begin
                    r_k <= r_k + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.final_res    = r_out_final;
    assign o_out.overflowed   = r_out_ovf;

endmodule

[rtl/hqs_ctrl.sv]
// ----------------------------------------------------------------------------
// hqs_ctrl
// Sequencer of the block sorter: load, insertion sort over the memory,
// then emit in order.
// ----------------------------------------------------------------------------
module hqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hqs_pkg::t_dp_stat i_stat,
    output hqs_pkg::t_dp_cmd  o_cmd
);
    import hqs_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = DP_LOAD;
        case (r_state)
            ST_LOAD: begin
                o_cmd.op = DP_LOAD;
                if (i_stat.in_last) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.op = DP_INIT;
                n_state  = i_stat.cnt_le1 ? ST_EMIT_RD : ST_RD_KEY;
            end
            ST_RD_KEY: begin
                o_cmd.op = DP_RD_KEY;
                n_state  = ST_KEY_CAP;
            end
            ST_KEY_CAP: begin
                o_cmd.op = DP_KEY_CAP;
                n_state  = ST_RD_PREV;
            end
            ST_RD_PREV: begin
                o_cmd.op = DP_RD_PREV;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                // shift the larger element up, or stop at the insertion point
                o_cmd.op = DP_CMP;
                if (i_stat.greater && !i_stat.j_one) begin
                    n_state = ST_RD_PREV;
                end else begin
                    n_state = ST_PUT_KEY;
                end
            end
            ST_PUT_KEY: begin
                o_cmd.op = DP_PUT_KEY;
                n_state  = i_stat.i_last ? ST_EMIT_RD : ST_RD_KEY;
            end
            ST_EMIT_RD: begin
                o_cmd.op = DP_EMIT_RD;
                n_state  = ST_EMIT_CAP;
            end
            ST_EMIT_CAP: begin
                o_cmd.op = DP_EMIT_CAP;
                n_state  = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                o_cmd.op = DP_EMIT_HOLD;
                if (i_stat.out_taken) begin
                    n_state = i_stat.k_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

[rtl/hybrid_quicksort_engine_core.sv]
// ----------------------------------------------------------------------------
// hybrid_quicksort_engine_core
// Load: one item per cycle. Sort: an insertion sort whose pace is set by the
// single read and single write port of the element memory; each shift is a
// read of the element below and a compare. Emit: each item is read, captured
// and held until the output side takes it.
// Synchronous active-low reset empties the block and clears the output.
// ----------------------------------------------------------------------------
module hybrid_quicksort_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hqs_in_if.sink     i_in,
    hqs_out_if.source  o_out
);
    import hqs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    hqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // memory and registers
    hqs_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

[dv/hqs_sort_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hqs_sort_checker
// Watches both channels of the block sorter. Collects each block as it is
// loaded, orders it ascending when the last item arrives and compares every
// emitted item, in order, against the expected sequence.
// ----------------------------------------------------------------------------
module hqs_sort_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    hqs_in_if    i_in_mon,
    hqs_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import hqs_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      is_final;
        logic                      overflowed;
    } t_sorted_item;

    t_sorted_item              sorted_expected[$];
    logic signed [VALUE_W-1:0] block_vals [MAX_ITEMS];
    int                        block_len;
    logic                      block_dropped;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        block_len     = 0;
        block_dropped = 1'b0;
    end

    // one line per mismatch, counted for the verdict
    task automatic flag_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // block collection, ordering and output comparison
    always @(posedge i_clk) begin
        logic signed [VALUE_W-1:0] ordered [MAX_ITEMS];
        logic signed [VALUE_W-1:0] key;
        int                        j;
        t_sorted_item              item;
        t_sorted_item              want;

        if (!i_rst_n) begin
            sorted_expected.delete();
            block_len     = 0;
            block_dropped = 1'b0;
        end else begin
            // element accepted: store it or note the drop
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (block_len < MAX_ITEMS) begin
                    block_vals[block_len] = i_in_mon.value;
                    block_len++;
                end else begin
                    block_dropped = 1'b1;
                end

                // block closed: insertion sort a copy and queue it in order
                if (i_in_mon.last) begin
                    for (int i = 0; i < block_len; i++)
                        ordered[i] = block_vals[i];
                    for (int i = 1; i < block_len; i++) begin
                        key = ordered[i];
                        j   = i;
                        while (j > 0 && ordered[j-1] > key) begin
                            ordered[j] = ordered[j-1];
                            j--;
                        end
                        ordered[j] = key;
                    end
                    for (int i = 0; i < block_len; i++) begin
                        item.value      = ordered[i];
                        item.is_final   = (i == block_len - 1);
                        item.overflowed = block_dropped;
                        sorted_expected.push_back(item);
                    end
                    block_len     = 0;
                    block_dropped = 1'b0;
                end
            end

            // sorted item accepted: compare with the oldest expectation
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (sorted_expected.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item, sorted_value %0d",
                                            i_out_mon.sorted_value));
                end else begin
                    want = sorted_expected.pop_front();
                    if (i_out_mon.sorted_value !== want.value)
                        flag_mismatch($sformatf("sorted_value %0d, expected %0d",
                                                i_out_mon.sorted_value, want.value));
                    if (i_out_mon.final_res !== want.is_final)
                        flag_mismatch($sformatf("final_res %b, expected %b",
                                                i_out_mon.final_res, want.is_final));
                    if (i_out_mon.overflowed !== want.overflowed)
                        flag_mismatch($sformatf("overflowed %b, expected %b",
                                                i_out_mon.overflowed, want.overflowed));
                end
            end
        end
        o_pending = sorted_expected.size();
    end

endmodule

[dv/tb_hybrid_quicksort_engine_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hybrid_quicksort_engine_core
// Feeds directed and random blocks of signed elements, including full and
// overflowing blocks, with random gaps on the input and random stalls on
// the output. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_hybrid_quicksort_engine_core;
    import hqs_pkg::*;

    localparam int IDLE_PCT    = 32;
    localparam int ITEM_TARGET = 260;
    localparam int STALL_LIMIT = 40000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm    = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;

    hqs_in_if  u_in_ch ();
    hqs_out_if u_out_ch ();

    hybrid_quicksort_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_ch),
        .o_out   (u_out_ch)
    );

    hqs_sort_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (u_in_ch),
        .i_out_mon    (u_out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // output backpressure, off during the calm stretch
    initial u_out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        u_out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // cycles without any accepted item on either channel
    always @(posedge i_clk) begin
        if ((u_in_ch.valid && u_in_ch.ready) || (u_out_ch.valid && u_out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    // present one element, entered and left at a falling edge
    task automatic push_element(input logic signed [VALUE_W-1:0] v, input logic l);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            u_in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        u_in_ch.valid = 1'b1;
        u_in_ch.value = v;
        u_in_ch.last  = l;
        @(posedge i_clk);
        while (!u_in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int                        blk_len;
        int                        blk_idx;
        int                        items_sent;
        int                        pick;
        logic signed [VALUE_W-1:0] v;

        u_in_ch.valid = 1'b0;
        u_in_ch.value = '0;
        u_in_ch.last  = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-element blocks at both extremes
        push_element(32'sh7fffffff, 1'b1);
        push_element(32'sh80000000, 1'b1);
        // extremes with repeated values
        push_element(32'sd0, 1'b0);
        push_element(-32'sd1, 1'b0);
        push_element(32'sh7fffffff, 1'b0);
        push_element(32'sh80000000, 1'b0);
        push_element(32'sd1, 1'b0);
        push_element(-32'sd1, 1'b1);
        // already ordered
        push_element(32'sd1, 1'b0);
        push_element(32'sd2, 1'b0);
        push_element(32'sd3, 1'b1);
        // reverse ordered
        push_element(32'sd3, 1'b0);
        push_element(32'sd2, 1'b0);
        push_element(32'sd1, 1'b0);
        push_element(-32'sd5, 1'b1);
        // all equal
        push_element(32'sd5, 1'b0);
        push_element(32'sd5, 1'b0);
        push_element(32'sd5, 1'b1);

        // random blocks: mostly short, one full, some past capacity
        blk_idx    = 0;
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            calm <= (blk_idx >= 8 && blk_idx < 14);
            if (blk_idx == 2)
                blk_len = MAX_ITEMS;
            else if (blk_idx == 5 || $urandom_range(0, 24) == 0)
                blk_len = MAX_ITEMS + $urandom_range(1, 3);
            else
                blk_len = $urandom_range(1, 12);
            for (int k = 0; k < blk_len; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    v = $urandom;
                else if (pick < 8)
                    v = $signed($urandom_range(0, 8)) - 4;
                else if (pick == 8)
                    v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                else
                    v = $urandom_range(0, 1) ? '0 : '1;
                push_element(v, k == blk_len - 1);
            end
            items_sent += blk_len;
            blk_idx++;
        end
        u_in_ch.valid = 1'b0;

        // drain and verdict
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
